// File: design/fpx_pkg.sv
//------------------------------------------------------------------------------
// fpx_pkg: shared types for the framed packet parser
// Parse phases, event codes, register indexes and the per-byte command record
// passed from the parser front end through the queue to the output stage.
//------------------------------------------------------------------------------
package fpx_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_MODULE  = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4,
		PH_TAIL    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_DATA    = 3'd1,
		EV_GOOD    = 3'd2,
		EV_CHKERR  = 3'd3,
		EV_TAILERR = 3'd4,
		EV_TOOLONG = 3'd5
	} event_t;

	localparam logic [1:0] CFG_START_BYTE = 2'd0;
	localparam logic [1:0] CFG_END_BYTE   = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

	localparam logic [7:0] START_BYTE_RST = 8'hA5;
	localparam logic [7:0] END_BYTE_RST   = 8'h5A;
	localparam logic [7:0] MAX_LENGTH_RST = 8'd255;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] max_length;
	} cfg_t;

	// one record per received byte
	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [7:0] idx;
		logic [7:0] module_id;
		logic [7:0] length;
	} cmd_t;

endpackage

// File: design/framed_packet_parser_xor_check.sv
//------------------------------------------------------------------------------
// framed_packet_parser_xor_check: byte-stream deframer with XOR check
// Hunts for a start byte, takes a module byte, a little-endian length, the
// payload, an XOR checksum and an end byte; one result beat per input beat.
//
//   channel   handshake          payload
//   input     push / full        rx_byte
//   result    empty / pop        event_res, data_byte, payload_index,
//                                module_id, payload_length
//   config    cfg_wen            cfg_index, cfg_data
//
// One input beat per cycle while full is low; the parser registers its frame
// state on each accepted beat. Each result is written to the queue and then
// loaded into the output register once that register is empty or popped.
// Reset clears the parser to hunting, the queue and the output register, and
// restores register defaults. The queue decouples the sides: full rises only
// after QUEUE_DEPTH+1 results wait.
//------------------------------------------------------------------------------
module framed_packet_parser_xor_check import fpx_pkg::*; #(
	parameter int LENGTH_FIELD_BYTES = 4,
	parameter int QUEUE_DEPTH        = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input beats
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	// result beats
	output logic       empty,
	input  logic       pop,
	output logic [2:0] event_res,
	output logic [7:0] data_byte,
	output logic [7:0] payload_index,
	output logic [7:0] module_id,
	output logic [7:0] payload_length,
	// configuration writes
	input  logic       cfg_wen,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t q_cmd;
	cmd_t res;
	logic in_fire;
	logic q_full, q_avail, q_rd;

	// register file; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
			cfg_q.max_length <= MAX_LENGTH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				CFG_END_BYTE:   cfg_q.end_byte   <= cfg_data;
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// every accepted byte produces exactly one command, so accept only with room
	assign full    = q_full;
	assign in_fire = push && !q_full;

	fpx_front #(
		.LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in_fire(in_fire),
		.in_byte(rx_byte),
		.cmd    (front_cmd)
	);

	fpx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (in_fire),
		.wr_cmd(front_cmd),
		.full  (q_full),
		.rd    (q_rd),
		.rd_cmd(q_cmd),
		.avail (q_avail)
	);

	fpx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_avail(q_avail),
		.q_cmd  (q_cmd),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign event_res      = res.ev;
	assign data_byte      = res.data;
	assign payload_index  = res.idx;
	assign module_id      = res.module_id;
	assign payload_length = res.length;

endmodule

// File: design/fpx_front.sv
//------------------------------------------------------------------------------
// fpx_front: frame parser front end
// Tracks the frame phase and turns every accepted byte into one command.
//------------------------------------------------------------------------------
module fpx_front import fpx_pkg::*; #(
	parameter int LENGTH_FIELD_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	output cmd_t       cmd
);

	localparam logic [1:0] LCOUNT_LAST = 2'(LENGTH_FIELD_BYTES - 1);

	phase_t     phase_q, phase_d;
	logic [7:0] module_q, module_d;
	logic [7:0] len_lo_q, len_lo_d;   // low byte of the length field
	logic       len_over_q, len_over_d; // some upper length byte was nonzero
	logic [1:0] lcount_q, lcount_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] xor_q, xor_d;
	logic [8:0] pos_inc;

	assign pos_inc = {1'b0, pos_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			module_q   <= '0;
			len_lo_q   <= '0;
			len_over_q <= 1'b0;
			lcount_q   <= '0;
			pos_q      <= '0;
			xor_q      <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			module_q   <= module_d;
			len_lo_q   <= len_lo_d;
			len_over_q <= len_over_d;
			lcount_q   <= lcount_d;
			pos_q      <= pos_d;
			xor_q      <= xor_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		module_d   = module_q;
		len_lo_d   = len_lo_q;
		len_over_d = len_over_q;
		lcount_d   = lcount_q;
		pos_d      = pos_q;
		xor_d      = xor_q;

		cmd.ev        = EV_NONE;
		cmd.data      = in_byte;
		cmd.idx       = pos_q;
		cmd.module_id = module_q;
		cmd.length    = len_lo_q;

		unique case (phase_q)
			PH_MODULE: begin
				module_d = in_byte;
				phase_d  = PH_LENGTH;
			end
			PH_LENGTH: begin
				// little-endian: only the first byte lands in the low byte
				if (lcount_q == 2'd0) begin
					len_lo_d = len_lo_q | in_byte;
				end else begin
					len_over_d = len_over_q | (in_byte != 8'd0);
				end
				lcount_d = lcount_q + 2'd1;
				if (lcount_q == LCOUNT_LAST) begin
					lcount_d = '0;
					pos_d    = '0;
					xor_d    = '0;
					phase_d  = (!len_over_d && len_lo_d == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pos_q == 8'd0 && (len_over_q || len_lo_q > cfg.max_length)) begin
					cmd.ev   = EV_TOOLONG;
					phase_d  = PH_HUNT;
					lcount_d = '0;
					pos_d    = '0;
					xor_d    = '0;
				end else begin
					cmd.ev = EV_DATA;
					xor_d  = xor_q ^ in_byte;
					pos_d  = pos_inc[7:0];
					if (pos_inc >= {1'b0, len_lo_q}) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				if (in_byte != xor_q) begin
					cmd.ev   = EV_CHKERR;
					phase_d  = PH_HUNT;
					lcount_d = '0;
					pos_d    = '0;
					xor_d    = '0;
				end else begin
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: begin
				cmd.ev   = (in_byte == cfg.end_byte) ? EV_GOOD : EV_TAILERR;
				phase_d  = PH_HUNT;
				lcount_d = '0;
				pos_d    = '0;
				xor_d    = '0;
			end
			default: begin
				// hunting, and any unused phase code
				if (in_byte == cfg.start_byte) begin
					phase_d    = PH_MODULE;
					len_lo_d   = '0;
					len_over_d = 1'b0;
					lcount_d   = '0;
					pos_d      = '0;
					xor_d      = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

endmodule

// File: design/fpx_queue.sv
//------------------------------------------------------------------------------
// fpx_queue: command queue between parser and output stage
// Small register FIFO; write and read may happen in the same cycle.
//------------------------------------------------------------------------------
module fpx_queue import fpx_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd,
	output cmd_t rd_cmd,
	output logic avail
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full   = (count_q == CW'(DEPTH));
	assign avail  = (count_q != '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && avail;
	assign rd_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/fpx_back.sv
//------------------------------------------------------------------------------
// fpx_back: result output stage
// Formats a queued command into result fields and holds it until popped.
//------------------------------------------------------------------------------
module fpx_back import fpx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_avail,
	input  cmd_t q_cmd,
	output logic q_rd,
	input  logic pop,
	output logic empty,
	output cmd_t res
);

	logic valid_q;
	cmd_t res_q;
	cmd_t fmt;

	// fields not meaningful for an event read as zero
	always_comb begin
		fmt    = q_cmd;
		unique case (q_cmd.ev) inside
			EV_DATA: begin
			end
			EV_GOOD, EV_CHKERR, EV_TAILERR: begin
				fmt.data = '0;
				fmt.idx  = '0;
			end
			EV_TOOLONG: begin
				fmt.data   = '0;
				fmt.idx    = '0;
				fmt.length = '0;
			end
			default: begin
				fmt.data      = '0;
				fmt.idx       = '0;
				fmt.module_id = '0;
				fmt.length    = '0;
			end
		endcase
	end

	assign q_rd  = q_avail && (!valid_q || pop);
	assign empty = !valid_q;
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			res_q <= fmt;
		end
	end

endmodule
